[sv/tnbc_pkg.sv]
// ---------------------------------------------------------------------------
// tnbc_pkg: shared types and constants
// Widths and stage payloads for the triangle normal and backface cull pipe.
// ---------------------------------------------------------------------------
package tnbc_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 14;
  localparam int NORM_W    = FRAC_BITS + 2;

  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W - 1;
  localparam int HALF_W  = (MAG_W + 1) / 2;
  localparam int HI_W    = MAG_W - HALF_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int DP_W    = CROSS_W + EDGE_W;
  localparam int DOT_W   = DP_W + 2;

  // root search: y = floor(2 * |c| * 2^F / |C|), one bit per stage
  localparam int ROOT_W    = FRAC_BITS + 2;
  localparam int BIT_IDX_W = $clog2(ROOT_W);
  localparam int M_SHIFT   = 2 * FRAC_BITS + 2;
  localparam int ACC_W     = SUM_W + ROOT_W;
  localparam int WORK_W    = SUM_W + 2 * ROOT_W + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

  typedef struct packed {
    logic [2:0][CROSS_W-1:0] c;
    logic [2:0][EDGE_W-1:0]  d;
  } front_t;

  typedef struct packed {
    logic [SUM_W-1:0]        s;
    logic [2:0][WORK_W-1:0]  rem;
    logic [2:0][ACC_W-1:0]   acc;
    logic [2:0][ROOT_W-1:0]  root;
    logic [2:0]              neg;
    logic                    render;
    logic                    degen;
  } root_t;

endpackage

[sv/tnbc_if.sv]
// ---------------------------------------------------------------------------
// tnbc_if: channel interfaces
// Triangle input, result output and camera register write channels.
// ---------------------------------------------------------------------------
interface tnbc_vtx_if;
  import tnbc_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_W-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_W-1:0] v2_x, v2_y, v2_z;
  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                v2_x, v2_y, v2_z, output ready);
endinterface

interface tnbc_res_if;
  import tnbc_pkg::*;
  logic valid;
  logic ready;
  logic render;
  logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
  logic degenerate;
  modport source (output valid, render, normal_x, normal_y, normal_z, degenerate,
                  input ready);
  modport sink (input valid, render, normal_x, normal_y, normal_z, degenerate,
                output ready);
endinterface

interface tnbc_cfg_if;
  import tnbc_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/tnbc_front.sv]
// ---------------------------------------------------------------------------
// tnbc_front: edge vectors and cross product
// Three stages: edges and eye offset, six products, cross components.
// ---------------------------------------------------------------------------
module tnbc_front (
  input  logic                          clk,
  input  logic                          rst,
  tnbc_vtx_if.sink                      vtx,
  input  logic signed [tnbc_pkg::COORD_W-1:0] cam_x,
  input  logic signed [tnbc_pkg::COORD_W-1:0] cam_y,
  input  logic signed [tnbc_pkg::COORD_W-1:0] cam_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tnbc_pkg::front_t              out_data
);
  import tnbc_pkg::*;

  logic v1, v2, v3;
  logic en1, en2, en3;
  logic signed [EDGE_W-1:0]  a [3];
  logic signed [EDGE_W-1:0]  b [3];
  logic signed [EDGE_W-1:0]  d1 [3];
  logic signed [EDGE_W-1:0]  d2 [3];
  logic signed [EDGE_W-1:0]  d3 [3];
  logic signed [PROD_W-1:0]  p [6];
  logic signed [CROSS_W-1:0] c [3];

  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign vtx.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= vtx.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      a[0]  <= EDGE_W'(vtx.v1_x) - EDGE_W'(vtx.v0_x);
      a[1]  <= EDGE_W'(vtx.v1_y) - EDGE_W'(vtx.v0_y);
      a[2]  <= EDGE_W'(vtx.v1_z) - EDGE_W'(vtx.v0_z);
      b[0]  <= EDGE_W'(vtx.v2_x) - EDGE_W'(vtx.v0_x);
      b[1]  <= EDGE_W'(vtx.v2_y) - EDGE_W'(vtx.v0_y);
      b[2]  <= EDGE_W'(vtx.v2_z) - EDGE_W'(vtx.v0_z);
      d1[0] <= EDGE_W'(vtx.v0_x) - EDGE_W'(cam_x);
      d1[1] <= EDGE_W'(vtx.v0_y) - EDGE_W'(cam_y);
      d1[2] <= EDGE_W'(vtx.v0_z) - EDGE_W'(cam_z);
    end
    if (en2) begin
      p[0] <= a[1] * b[2];
      p[1] <= a[2] * b[1];
      p[2] <= a[2] * b[0];
      p[3] <= a[0] * b[2];
      p[4] <= a[0] * b[1];
      p[5] <= a[1] * b[0];
      d2   <= d1;
    end
    if (en3) begin
      c[0] <= CROSS_W'(p[0]) - CROSS_W'(p[1]);
      c[1] <= CROSS_W'(p[2]) - CROSS_W'(p[3]);
      c[2] <= CROSS_W'(p[4]) - CROSS_W'(p[5]);
      d3   <= d2;
    end
  end

  assign out_valid = v3;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_data.c[i] = c[i];
      out_data.d[i] = d3[i];
    end
  end

endmodule

[sv/tnbc_energy.sv]
// ---------------------------------------------------------------------------
// tnbc_energy: squared length and view dot product
// Three stages: split squares and dot terms, sums, setup of the root search.
// ---------------------------------------------------------------------------
module tnbc_energy (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tnbc_pkg::front_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tnbc_pkg::root_t   out_data
);
  import tnbc_pkg::*;

  logic v4, v5, v6;
  logic en4, en5, en6;
  logic [2*HI_W-1:0]         hh [3];
  logic [HI_W+HALF_W-1:0]    hl [3];
  logic [2*HALF_W-1:0]       ll [3];
  logic signed [DP_W-1:0]    dp [3];
  logic [2:0]                neg4, neg5;
  logic                      zero4, zero5;
  logic [SQ_W-1:0]           sq [3];
  logic signed [DOT_W-1:0]   dot;
  logic [MAG_W-1:0]          mag [3];
  root_t                     r6;

  assign en6 = !v6 || out_ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign in_ready = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = in_data.c[i][CROSS_W-1] ? MAG_W'(-$signed(in_data.c[i]))
                                       : MAG_W'(in_data.c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        hh[i]   <= mag[i][MAG_W-1:HALF_W] * mag[i][MAG_W-1:HALF_W];
        hl[i]   <= mag[i][MAG_W-1:HALF_W] * mag[i][HALF_W-1:0];
        ll[i]   <= mag[i][HALF_W-1:0] * mag[i][HALF_W-1:0];
        dp[i]   <= $signed(in_data.c[i]) * $signed(in_data.d[i]);
        neg4[i] <= in_data.c[i][CROSS_W-1];
      end
      zero4 <= (in_data.c == '0);
    end
    if (en5) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (SQ_W'(hh[i]) << (2 * HALF_W)) + (SQ_W'(hl[i]) << (HALF_W + 1))
                 + SQ_W'(ll[i]);
      end
      dot   <= DOT_W'(dp[0]) + DOT_W'(dp[1]) + DOT_W'(dp[2]);
      neg5  <= neg4;
      zero5 <= zero4;
    end
    if (en6) begin
      r6.s <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      for (int i = 0; i < 3; i++) begin
        r6.rem[i]  <= WORK_W'(sq[i]) << M_SHIFT;
        r6.acc[i]  <= '0;
        r6.root[i] <= '0;
      end
      r6.neg    <= neg5;
      r6.render <= !zero5 && dot[DOT_W-1];
      r6.degen  <= zero5;
    end
  end

  assign out_valid = v6;
  assign out_data  = r6;

endmodule

[sv/tnbc_root_step.sv]
// ---------------------------------------------------------------------------
// tnbc_root_step: one bit of the scaled root-quotient search
// Tries y + 2^k against y^2 * s <= c^2 * 2^(2F+2) using shifts of y*s.
// ---------------------------------------------------------------------------
module tnbc_root_step (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tnbc_pkg::BIT_IDX_W-1:0]  bit_idx,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tnbc_pkg::root_t                 in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tnbc_pkg::root_t                 out_data
);
  import tnbc_pkg::*;

  logic              v;
  logic              en;
  logic [WORK_W-1:0] term [3];
  logic [WORK_W-1:0] s_ext;
  root_t             nxt;
  root_t             r;

  assign en = !v || out_ready;
  assign in_ready = en;

  always_comb begin
    nxt   = in_data;
    s_ext = WORK_W'(in_data.s);
    for (int i = 0; i < 3; i++) begin
      // (y + 2^k)^2 s - y^2 s = 2^(k+1) y s + 2^(2k) s
      term[i] = ((WORK_W'(in_data.acc[i]) << bit_idx) << 1)
                + (s_ext << {bit_idx, 1'b0});
      if (term[i] <= in_data.rem[i]) begin
        nxt.rem[i]  = in_data.rem[i] - term[i];
        nxt.acc[i]  = in_data.acc[i] + (ACC_W'(in_data.s) << bit_idx);
        nxt.root[i] = in_data.root[i] | (ROOT_W'(1) << bit_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else if (en) v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) r <= nxt;
  end

  assign out_valid = v;
  assign out_data  = r;

endmodule

[sv/tnbc_pack.sv]
// ---------------------------------------------------------------------------
// tnbc_pack: rounding, sign and output register
// Halves the root with round-half-up, applies the sign, zeroes degenerates.
// ---------------------------------------------------------------------------
module tnbc_pack (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tnbc_pkg::root_t  in_data,
  tnbc_res_if.source       res
);
  import tnbc_pkg::*;

  logic                     v;
  logic                     en;
  logic [ROOT_W:0]          half_sum [3];
  logic [NORM_W-1:0]        mag [3];
  logic [NORM_W-1:0]        nrm [3];
  logic [NORM_W-1:0]        nrm_q [3];
  logic                     render_q, degen_q;

  assign en = !v || res.ready;
  assign in_ready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      half_sum[i] = {1'b0, in_data.root[i]} + 1'b1;
      mag[i]      = NORM_W'(half_sum[i][ROOT_W:1]);
      nrm[i]      = in_data.degen ? '0 : (in_data.neg[i] ? (~mag[i] + 1'b1) : mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else if (en) v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_q    <= nrm;
      render_q <= in_data.render;
      degen_q  <= in_data.degen;
    end
  end

  assign res.valid      = v;
  assign res.render     = render_q;
  assign res.degenerate = degen_q;
  assign res.normal_x   = nrm_q[0];
  assign res.normal_y   = nrm_q[1];
  assign res.normal_z   = nrm_q[2];

endmodule

[sv/triangle_normal_backface_cull.sv]
// ---------------------------------------------------------------------------
// triangle_normal_backface_cull: unit face normal and backface test
// Exact cross product, Q1.14 unit normal rounded to nearest, camera cull.
// ---------------------------------------------------------------------------
// Takes one triangle per cycle while the output side does not stall and returns
// one result per triangle, in order. 3 stages form edges and the exact cross
// product C, 3 stages form |C|^2 and the dot product of C with (v0 - camera),
// 16 stages resolve one bit each of floor(2 * |C_i| * 2^14 / |C|) for all three
// axes in parallel, and one output register rounds half away from zero and
// applies the sign. Every stage has its own valid bit and accepts a new item
// whenever it is empty or moving, so bubbles close up and the input keeps
// taking transfers while a finished result waits at the output, until the
// stages ahead are full. A zero cross product yields a zero normal,
// degenerate = 1 and render = 0. render = 1 means C . (v0 - camera) < 0.
// Camera registers (index 0/1/2 = x/y/z, reset 0) are written through cfg,
// which is always ready; writes to other indexes are dropped.
// ---------------------------------------------------------------------------
module triangle_normal_backface_cull (
  input  logic        clk,
  input  logic        rst,
  tnbc_vtx_if.sink    vtx,
  tnbc_res_if.source  res,
  tnbc_cfg_if.sink    cfg
);
  import tnbc_pkg::*;

  // camera position
  logic signed [COORD_W-1:0] camera_x, camera_y, camera_z;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CAMERA_X: camera_x <= cfg.data;
        REG_CAMERA_Y: camera_y <= cfg.data;
        REG_CAMERA_Z: camera_z <= cfg.data;
        default: ;
      endcase
    end
  end

  // front: edges and cross product
  logic   fr_valid, fr_ready;
  front_t fr_data;

  tnbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .vtx       (vtx),
    .cam_x     (camera_x),
    .cam_y     (camera_y),
    .cam_z     (camera_z),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  // chain[0] is the energy stage output, chain[ROOT_W] feeds the packer
  logic  ch_valid [ROOT_W+1];
  logic  ch_ready [ROOT_W+1];
  root_t ch_data  [ROOT_W+1];

  tnbc_energy u_energy (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (ch_valid[0]),
    .out_ready (ch_ready[0]),
    .out_data  (ch_data[0])
  );

  // root search, most significant bit first
  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    tnbc_root_step u_step (
      .clk       (clk),
      .rst       (rst),
      .bit_idx   (BIT_IDX_W'(ROOT_W - 1 - j)),
      .in_valid  (ch_valid[j]),
      .in_ready  (ch_ready[j]),
      .in_data   (ch_data[j]),
      .out_valid (ch_valid[j+1]),
      .out_ready (ch_ready[j+1]),
      .out_data  (ch_data[j+1])
    );
  end

  tnbc_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ch_valid[ROOT_W]),
    .in_ready (ch_ready[ROOT_W]),
    .in_data  (ch_data[ROOT_W]),
    .res      (res)
  );

  // degenerate faces carry no normal and are never drawn
  a_degen_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.degenerate |-> !res.render && res.normal_x == '0
      && res.normal_y == '0 && res.normal_z == '0)
    else $error("degenerate result with nonzero normal or render");

  // the normal_x component stays within +/- 1.0
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> $signed(res.normal_x) <= $signed(NORM_W'(1 << FRAC_BITS))
      && $signed(res.normal_x) >= -$signed(NORM_W'(1 << FRAC_BITS)))
    else $error("normal_x out of unit range");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid after reset");

endmodule
